// ===== rtl/core/hex_stream_to_jtag_shift_dr_assert.svh =====
// Assertion macros for the hex stream to JTAG Shift-DR serializer.
// Used by the port checker; needs clk and rst_n in the scope of use.
`ifndef HEX_STREAM_TO_JTAG_SHIFT_DR_ASSERT_SVH
`define HEX_STREAM_TO_JTAG_SHIFT_DR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define HSJ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define HSJ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hsj_pkg.sv =====
// Shared types, constants and helpers of the hex stream to JTAG Shift-DR serializer.
// No dependencies.
package hsj_pkg;

    // Nibble counter width and reported count width
    localparam int COUNT_BITS = 24;
    localparam int OUT_CNT_W  = 24;

    // Command queue between front and back
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CASE_MASK = 8'hDF;
    localparam logic [3:0] LETTER_OFS = 4'd9;

    // Beat positions inside one command
    localparam int BEAT_W = 3;
    localparam logic [BEAT_W-1:0] BEAT_FIRST     = 3'd0;
    localparam logic [BEAT_W-1:0] BEAT_DATA_LAST = 3'd3;
    localparam logic [BEAT_W-1:0] BEAT_UPDATE    = 3'd4;

    typedef enum logic [1:0] {
        CMD_SHIFT  = 2'd0,
        CMD_FINAL  = 2'd1,
        CMD_STATUS = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        ST_SHIFTING = 2'd0,
        ST_DONE     = 2'd1,
        ST_NODATA   = 2'd2
    } status_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [3:0]            nibble;
        logic [OUT_CNT_W-1:0]  count;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cq_stat_t;

    // Low bits of the counter, zero-extended where the counter is narrower
    function automatic logic [OUT_CNT_W-1:0] out_count(input logic [COUNT_BITS-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[OUT_CNT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/hsj_cmd_fifo.sv =====
// Command queue between the classifying front and the shifting back.
// Depends on hsj_pkg.
module hsj_cmd_fifo
    import hsj_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  cmd_t     wr_data,
    input  logic     rd_en,
    output cmd_t     rd_data,
    output cq_stat_t stat
);

    cmd_t                slot_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg;
    logic [CQ_PTR_W-1:0] rd_ptr_reg;
    logic [CQ_CNT_W-1:0] fill_reg;
    logic                do_wr;
    logic                do_rd;

    assign stat.full  = (fill_reg == CQ_CNT_W'(CQ_DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = slot_reg[rd_ptr_reg];

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/hsj_front.sv =====
// Front end: accepts characters, tracks the held nibble, abort and count,
// and queues shift, final or status commands. Depends on hsj_pkg.
module hsj_front
    import hsj_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] char_code,
    output logic       full,
    input  cq_stat_t   cq_stat,
    output logic       cq_push,
    output cmd_t       cq_data
);

    logic [3:0]            held_nibble_reg, held_nibble_next;
    logic                  held_valid_reg,  held_valid_next;
    logic                  aborted_reg,     aborted_next;
    logic [COUNT_BITS-1:0] count_reg,       count_next;

    logic                  accept;
    logic [7:0]            upper;
    logic                  is_dot;
    logic                  is_dec;
    logic                  is_alpha;
    logic                  is_bad;
    logic [3:0]            digit;
    logic                  shifting;
    logic [COUNT_BITS-1:0] count_inc;

    assign full   = cq_stat.full;
    assign accept = push && !full;

    // Classify the character
    always_comb
    begin
        upper    = char_code & CASE_MASK;
        is_dot   = (char_code == CH_DOT);
        is_dec   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        is_alpha = (upper >= CH_UPPER_A) && (upper <= CH_UPPER_F);
        is_bad   = (char_code > CH_SPACE);
        digit    = is_dec ? char_code[3:0] : (char_code[3:0] + LETTER_OFS);
        shifting = held_valid_reg && !aborted_reg;
        count_inc = (count_reg == '1) ? count_reg : (count_reg + COUNT_BITS'(1));
    end

    // Update stream state and build the command
    always_comb
    begin
        held_nibble_next = held_nibble_reg;
        held_valid_next  = held_valid_reg;
        aborted_next     = aborted_reg;
        count_next       = count_reg;
        cq_push          = 1'b0;
        cq_data.kind     = CMD_STATUS;
        cq_data.nibble   = held_nibble_reg;
        cq_data.count    = out_count(count_reg);
        if (accept)
        begin
            priority if (is_dot)
            begin
                cq_push = 1'b1;
                if (shifting)
                begin
                    cq_data.kind  = CMD_FINAL;
                    cq_data.count = out_count(count_inc);
                end
                held_nibble_next = '0;
                held_valid_next  = 1'b0;
                aborted_next     = 1'b0;
                count_next       = '0;
            end
            else if (is_dec || is_alpha)
            begin
                if (shifting)
                begin
                    cq_push       = 1'b1;
                    cq_data.kind  = CMD_SHIFT;
                    cq_data.count = out_count(count_inc);
                    count_next    = count_inc;
                end
                held_nibble_next = digit;
                held_valid_next  = 1'b1;
            end
            else if (is_bad)
            begin
                cq_push      = 1'b1;
                aborted_next = 1'b1;
            end
            else
            begin
                // drop whitespace and control characters
                cq_push = 1'b0;
            end
        end
    end

    // Hold stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_nibble_reg <= '0;
            held_valid_reg  <= 1'b0;
            aborted_reg     <= 1'b0;
            count_reg       <= '0;
        end
        else
        begin
            held_nibble_reg <= held_nibble_next;
            held_valid_reg  <= held_valid_next;
            aborted_reg     <= aborted_next;
            count_reg       <= count_next;
        end
    end

endmodule

// ===== rtl/core/hsj_back.sv =====
// Back end: expands queued commands into TCK beats and status results, one
// per cycle into an output register unless it stalls. Depends on hsj_pkg.
module hsj_back
    import hsj_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cq_stat_t             cq_stat,
    input  cmd_t                 cq_data,
    output logic                 cq_pop,
    input  logic                 pop,
    output logic                 empty,
    output logic                 pin_tms,
    output logic                 pin_tdi,
    output logic                 clock_valid,
    output logic [1:0]           status,
    output logic [OUT_CNT_W-1:0] nibbles_done,
    output logic                 last
);

    cmd_t              cmd_reg, cmd_next;
    logic              cmd_valid_reg, cmd_valid_next;
    logic [BEAT_W-1:0] beat_reg, beat_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 tms_reg, tdi_reg, clk_reg, last_reg;
    status_t              status_reg;
    logic [OUT_CNT_W-1:0] count_reg;

    logic                 advance;
    logic                 final_beat;
    logic                 r_tms, r_tdi, r_clk, r_last;
    status_t              r_status;

    assign advance = !out_valid_reg || pop;

    // Form the result of the current beat
    always_comb
    begin
        r_tms      = 1'b0;
        r_tdi      = 1'b0;
        r_clk      = 1'b0;
        r_last     = 1'b0;
        r_status   = ST_NODATA;
        final_beat = 1'b1;
        unique case (cmd_reg.kind)
            CMD_SHIFT:
            begin
                r_clk      = 1'b1;
                r_status   = ST_SHIFTING;
                r_tdi      = cmd_reg.nibble[2'(BEAT_DATA_LAST - beat_reg)];
                final_beat = (beat_reg == BEAT_DATA_LAST);
                r_last     = final_beat;
            end
            CMD_FINAL:
            begin
                r_clk      = 1'b1;
                final_beat = (beat_reg == BEAT_UPDATE);
                if (final_beat)
                begin
                    r_tms    = 1'b1;
                    r_tdi    = 1'b1;
                    r_last   = 1'b1;
                    r_status = ST_DONE;
                end
                else
                begin
                    r_status = ST_SHIFTING;
                    r_tdi    = cmd_reg.nibble[2'(BEAT_DATA_LAST - beat_reg)];
                    r_tms    = (beat_reg == BEAT_DATA_LAST);
                end
            end
            default:
            begin
                r_last = 1'b1;
            end
        endcase
    end

    // Step beats and fetch the next command
    always_comb
    begin
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg;
        beat_next      = beat_reg;
        out_valid_next = out_valid_reg;
        cq_pop         = 1'b0;
        if (advance)
        begin
            out_valid_next = cmd_valid_reg;
        end
        if (!cmd_valid_reg || (advance && final_beat))
        begin
            cq_pop         = !cq_stat.empty;
            cmd_valid_next = !cq_stat.empty;
            cmd_next       = cq_data;
            beat_next      = BEAT_FIRST;
        end
        else if (advance)
        begin
            beat_next = beat_reg + 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            beat_reg      <= BEAT_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            beat_reg      <= beat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load command and output payload
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (advance && cmd_valid_reg)
        begin
            tms_reg    <= r_tms;
            tdi_reg    <= r_tdi;
            clk_reg    <= r_clk;
            last_reg   <= r_last;
            status_reg <= r_status;
            count_reg  <= cmd_reg.count;
        end
    end

    assign empty        = !out_valid_reg;
    assign pin_tms      = tms_reg;
    assign pin_tdi      = tdi_reg;
    assign clock_valid  = clk_reg;
    assign status       = status_reg;
    assign nibbles_done = count_reg;
    assign last         = last_reg;

endmodule

// ===== rtl/core/hex_stream_to_jtag_shift_dr.sv =====
// Top level of the hex stream to JTAG Shift-DR serializer: front, command
// queue and back. Depends on hsj_pkg, hsj_front, hsj_cmd_fifo, hsj_back.
//
// Channel  | Handshake      | Payload
// ---------+----------------+------------------------------------------------
// input    | push / full    | char_code
// result   | empty / pop    | pin_tms pin_tdi clock_valid status nibbles_done last
//
// A character is taken every cycle while the command queue has room, also
// while the back end still works. A hex digit makes 4 results if a digit is
// held and not aborted, else 0; the end mark up to 5, others 1 or 0. The
// back end emits one result per cycle while its output register is empty or
// popped. A result passes the queue, command register and output register.
// Reset is asynchronous and empties queue and output register. full rises
// when the 4-entry queue fills; a held result stays until popped.
module hex_stream_to_jtag_shift_dr
    import hsj_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           char_code,
    output logic                 empty,
    input  logic                 pop,
    output logic                 pin_tms,
    output logic                 pin_tdi,
    output logic                 clock_valid,
    output logic [1:0]           status,
    output logic [OUT_CNT_W-1:0] nibbles_done,
    output logic                 last
);

    cq_stat_t cq_stat;
    logic     cq_push;
    logic     cq_pop;
    cmd_t     cq_wr_data;
    cmd_t     cq_rd_data;

    // Classify characters
    hsj_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .char_code (char_code),
        .full      (full),
        .cq_stat   (cq_stat),
        .cq_push   (cq_push),
        .cq_data   (cq_wr_data)
    );

    // Decouple front and back
    hsj_cmd_fifo u_cq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cq_push),
        .wr_data (cq_wr_data),
        .rd_en   (cq_pop),
        .rd_data (cq_rd_data),
        .stat    (cq_stat)
    );

    // Expand commands into pin beats
    hsj_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cq_stat      (cq_stat),
        .cq_data      (cq_rd_data),
        .cq_pop       (cq_pop),
        .pop          (pop),
        .empty        (empty),
        .pin_tms      (pin_tms),
        .pin_tdi      (pin_tdi),
        .clock_valid  (clock_valid),
        .status       (status),
        .nibbles_done (nibbles_done),
        .last         (last)
    );

endmodule

// ===== rtl/core/hsj_checker.sv =====
// Port-level checker for the hex stream to JTAG Shift-DR serializer, bound
// to the top level. Depends on hsj_pkg and the assertion macro header.
`include "hex_stream_to_jtag_shift_dr_assert.svh"

module hsj_checker
    import hsj_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  logic [7:0]           char_code,
    input  logic                 empty,
    input  logic                 pop,
    input  logic                 pin_tms,
    input  logic                 pin_tdi,
    input  logic                 clock_valid,
    input  logic [1:0]           status,
    input  logic [OUT_CNT_W-1:0] nibbles_done,
    input  logic                 last
);

    logic [OUT_CNT_W+5:0] result_bits;

    assign result_bits = {pin_tms, pin_tdi, clock_valid, status, nibbles_done, last};

    // A stalled result holds
    `HSJ_ASSERT_NXT(a_result_hold, !empty && !pop, !empty && $stable(result_bits), "result changed while stalled")

    // A status-only result ends its transaction and shows no-data status
    `HSJ_ASSERT_IMP(a_status_only, !empty && !clock_valid, !pin_tms && !pin_tdi && last && (status == ST_NODATA), "bad status-only result")

    // The done result is the Update-DR clock
    `HSJ_ASSERT_IMP(a_done_update, !empty && (status == ST_DONE), clock_valid && pin_tms && pin_tdi && last, "bad Update-DR result")

    // A data clock counts the nibble it belongs to
    `HSJ_ASSERT_IMP(a_shift_count, !empty && (status == ST_SHIFTING), clock_valid && (nibbles_done != '0), "data clock without count")

    logic unused_inputs;
    assign unused_inputs = push ^ full ^ (^char_code);

endmodule

bind hex_stream_to_jtag_shift_dr hsj_checker u_hsj_checker (.*);

// ===== dv/tb_top.sv =====
// Testbench for hex_stream_to_jtag_shift_dr: directed edge characters, then random hex
// streams under three idle mixes, checked against an in-bench JTAG beat predictor.
// Depends on hsj_pkg and the hex_stream_to_jtag_shift_dr RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hsj_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // One expected TCK beat or status report
    typedef struct packed {
        logic                 tms;
        logic                 tdi;
        logic                 tck;
        status_t              st;
        logic [OUT_CNT_W-1:0] count;
        logic                 last;
    } jtag_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [7:0]           char_code = 8'h00;
    logic                 empty;
    logic                 pop = 1'b0;
    logic                 pin_tms;
    logic                 pin_tdi;
    logic                 clock_valid;
    logic [1:0]           status;
    logic [OUT_CNT_W-1:0] nibbles_done;
    logic                 last;

    // Predictor state of the serializer
    logic [3:0]            held_nib = 4'd0;
    logic                  held_ok = 1'b0;
    logic                  abort_seen = 1'b0;
    logic [COUNT_BITS-1:0] nib_count = '0;

    jtag_beat_t pending_beats[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int errors = 0;
    int chars_sent = 0;
    int stream_ends = 0;
    int results_checked = 0;
    int cycles = 0;

    hex_stream_to_jtag_shift_dr dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .char_code    (char_code),
        .empty        (empty),
        .pop          (pop),
        .pin_tms      (pin_tms),
        .pin_tdi      (pin_tdi),
        .clock_valid  (clock_valid),
        .status       (status),
        .nibbles_done (nibbles_done),
        .last         (last)
    );

    always #5 clk = ~clk;

    // Queue one expected beat, tagged with the current nibble count
    function automatic void add_beat(input logic tms, input logic tdi, input logic tck,
                                     input status_t st, input logic lst);
        jtag_beat_t b;
        logic [31:0] wide;
        wide    = 32'(nib_count);
        b.tms   = tms;
        b.tdi   = tdi;
        b.tck   = tck;
        b.st    = st;
        b.count = wide[OUT_CNT_W-1:0];
        b.last  = lst;
        pending_beats.push_back(b);
    endfunction

    // Clock the held nibble out MSB first; the count includes this nibble
    function automatic void clock_held_nibble(input logic final_tms, input logic last_on_fourth);
        if (nib_count != '1)
            nib_count = nib_count + 1'b1;
        for (int i = 3; i >= 0; i--)
            add_beat((i == 0) ? final_tms : 1'b0, held_nib[i], 1'b1, ST_SHIFTING,
                     (i == 0) ? last_on_fourth : 1'b0);
    endfunction

    // Work out the beats caused by one accepted character
    function automatic void predict_char(input logic [7:0] c);
        logic [7:0] up;
        logic [7:0] sum;
        logic [3:0] val;
        logic       is_hex;
        up     = c & CASE_MASK;
        is_hex = 1'b0;
        val    = 4'd0;
        if (c == CH_DOT)
        begin
            if (held_ok && !abort_seen)
            begin
                clock_held_nibble(1'b1, 1'b0);
                add_beat(1'b1, 1'b1, 1'b1, ST_DONE, 1'b1);
            end
            else
                add_beat(1'b0, 1'b0, 1'b0, ST_NODATA, 1'b1);
            held_ok    = 1'b0;
            held_nib   = 4'd0;
            abort_seen = 1'b0;
            nib_count  = '0;
            stream_ends++;
            return;
        end
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            val    = c[3:0];
            is_hex = 1'b1;
        end
        else if (up >= CH_UPPER_A && up <= CH_UPPER_F)
        begin
            sum    = c + 8'd9;
            val    = sum[3:0];
            is_hex = 1'b1;
        end
        if (is_hex)
        begin
            // hold the new digit, release the old one
            if (held_ok && !abort_seen)
                clock_held_nibble(1'b0, 1'b1);
            held_nib = val;
            held_ok  = 1'b1;
        end
        else if (c > CH_SPACE)
        begin
            abort_seen = 1'b1;
            add_beat(1'b0, 1'b0, 1'b0, ST_NODATA, 1'b1);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
                 $realtime, what, got, want, results_checked);
        errors++;
    endtask

    // Send one character: idle at random, then hold push until the transaction lands
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_char(c);
        chars_sent++;
    endtask

    // Drop push and drain every expected beat, then let the pipeline settle
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Edge characters: empty end mark, whitespace, both digit cases, abort paths
    task automatic test_directed_edges();
        logic [7:0] seq[$];
        tx_idle_pct = 0;
        rx_idle_pct = 30;
        seq = '{CH_DOT,                 // end mark with nothing held
                8'h00, 8'h1F, CH_SPACE,  // ignored control and space
                CH_ZERO, CH_NINE,
                8'h61, 8'h66,            // 'a' 'f'
                CH_UPPER_A, CH_UPPER_F,
                CH_DOT,                  // end mark with a held digit
                8'h33, 8'h47, 8'h37,     // '3', 'G' aborts, '7' held but not clocked
                CH_DOT,                  // end mark after abort
                8'h21,                   // '!' just above space
                8'hFF, 8'h80,            // high characters
                8'h2F, 8'h3A, 8'h40,     // '/', ':', '@' around the digit ranges
                8'h60, 8'h67, 8'h7F,     // '`', 'g', DEL
                CH_DOT};
        foreach (seq[i])
            send_char(seq[i]);
        wait_idle();
    endtask

    // Mostly well-formed streams with random digits, some whitespace and noise
    task automatic test_stream_traffic(input int n_items, input int tx_pct, input int rx_pct);
        int         counted;
        int         len;
        int         v;
        logic [7:0] c;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        counted     = 0;
        while (counted < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(9) == 0)
                    send_char(8'($urandom_range(32)));
                if ($urandom_range(24) == 0)
                    c = 8'($urandom_range(255));
                else
                begin
                    v = $urandom_range(15);
                    if (v < 10)
                        c = CH_ZERO + 8'(v);
                    else
                        c = (CH_UPPER_A + 8'(v - 10)) | ($urandom_range(1) ? 8'h20 : 8'h00);
                end
                send_char(c);
                if (c > CH_SPACE)
                    counted++;
            end
            // usually close the stream; sometimes let it run into the next
            if ($urandom_range(9) != 0)
            begin
                send_char(CH_DOT);
                counted++;
            end
        end
        wait_idle();
    endtask

    // Check each popped result against the oldest expectation, then pick the next pop
    always @(posedge clk)
    begin : result_check
        jtag_beat_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (pending_beats.size() == 0)
                    report_mismatch("unexpected result status", 32'(status), 32'h0);
                else
                begin
                    want = pending_beats.pop_front();
                    if (pin_tms !== want.tms)
                        report_mismatch("pin_tms", 32'(pin_tms), 32'(want.tms));
                    if (pin_tdi !== want.tdi)
                        report_mismatch("pin_tdi", 32'(pin_tdi), 32'(want.tdi));
                    if (clock_valid !== want.tck)
                        report_mismatch("clock_valid", 32'(clock_valid), 32'(want.tck));
                    if (status !== want.st)
                        report_mismatch("status", 32'(status), 32'(want.st));
                    if (nibbles_done !== want.count)
                        report_mismatch("nibbles_done", 32'(nibbles_done), 32'(want.count));
                    if (last !== want.last)
                        report_mismatch("last", 32'(last), 32'(want.last));
                end
                results_checked++;
            end
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_stream_traffic(75, 8, 60);
        test_stream_traffic(75, 60, 8);
        test_stream_traffic(65, 0, 0);

        $display("Sent %0d characters over %0d stream ends; checked %0d results.",
                 chars_sent, stream_ends, results_checked);
        $display("Idle mixes: sender 8%%/receiver 60%%, sender 60%%/receiver 8%%, none.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hsj_pkg.sv
rtl/core/hsj_cmd_fifo.sv
rtl/core/hsj_front.sv
rtl/core/hsj_back.sv
rtl/core/hex_stream_to_jtag_shift_dr.sv
rtl/core/hsj_checker.sv
dv/tb_top.sv
